// ===== hw/rtl/gww_pkg.sv =====
// Shared types, constants and helpers for the greedy word wrapper.
package gww_pkg;

    localparam int MAX_WIDTH_DEF = 56;
    localparam int CFG_W         = 6;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 6'd56;

    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_WORD,
        ST_SUFFIX
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_SPACE,
        PFX_NEWLINE
    } pfx_t;

    function automatic logic is_separator(input logic [7:0] b);
        return (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_CR) ||
               (b == CHAR_VT) || (b == CHAR_FF);
    endfunction

endpackage

// ===== hw/rtl/gww_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface gww_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/gww_cell.sv =====
// One byte cell of the word store chain: loads a new character or takes its neighbor's byte.
module gww_cell (
    input  logic       clk,
    input  logic       load,
    input  logic       shift,
    input  logic [7:0] load_data,
    input  logic [7:0] shift_data,
    output logic [7:0] data
);
    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule

// ===== hw/rtl/gww_chain.sv =====
// Row of byte cells holding the pending word; it drains toward cell 0 one byte per shift.
module gww_chain #(
    parameter int DEPTH = gww_pkg::MAX_WIDTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [7:0]       wr_data,
    input  logic             shift,
    output logic [7:0]       head
);
    logic [7:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] neighbor;

        if (i == DEPTH - 1)
        begin : g_tail
            assign neighbor = 8'h00;
        end
        else
        begin : g_mid
            assign neighbor = cell_data[i+1];
        end

        gww_cell u_cell (
            .clk        (clk),
            .load       (wr_en && (wr_idx == IDX_W'(i))),
            .shift      (shift),
            .load_data  (wr_data),
            .shift_data (neighbor),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];
endmodule

// ===== hw/rtl/greedy_word_wrapper.sv =====
// Greedy word wrapper top level: line planner, output sequencer and word store chain.
//
// Usage: text bytes enter on text_in (valid/ready), each transaction carrying
// text_byte and end_of_text. Wrapped text leaves on text_out, one byte per
// transaction, with run_last set on the last byte caused by an input byte.
// The line width is written through cfg_wr_en/cfg_wr_data by the user, only
// while the block is idle; the block does not enforce this. Values of 0 act
// as 1 and values above MAX_WIDTH act as MAX_WIDTH.
// An input byte that causes no output leaves the sequencer idle, so such
// bytes can be accepted every cycle. Otherwise the sequencer sends an
// optional space or newline, then the word drained from the cell chain one
// byte per cycle while the receiver is ready, then an optional newline. The
// first output byte is registered after the sequencer leaves idle. The
// output register holds the last byte while the next input is taken.
// A stalled receiver freezes the sequencer and the chain; nothing is lost.
// Reset sets the line width to 56 and empties the word and line counts;
// the word store itself needs no clearing.
module greedy_word_wrapper #(
    parameter int MAX_WIDTH = gww_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    gww_stream_if.sink               text_in,
    gww_stream_if.source             text_out,
    input  logic                     cfg_wr_en,
    input  logic [gww_pkg::CFG_W-1:0] cfg_wr_data
);
    import gww_pkg::*;

    localparam int LEN_W = $clog2(MAX_WIDTH + 1);
    localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SUM_W = CFG_W + 2;

    state_t           state_reg, state_next;
    pfx_t             pfx_reg, pfx_next;
    logic             suffix_reg, suffix_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [CFG_W-1:0] width_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;

    logic [7:0] in_byte;
    logic       in_eot;
    logic       accept;
    logic       is_nl, is_sep, is_chr;
    logic       has_room;
    logic [CFG_W-1:0] w_eff;
    logic [LEN_W-1:0] w1, fin_len, line_mid;
    logic       full, do_finish, ending;
    pfx_t       plan_pfx;
    logic [LEN_W-1:0] plan_cnt, plan_word_len;
    logic       plan_suffix;

    logic       out_ok;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       chain_shift;
    logic [7:0] chain_head;

    assign in_byte = text_in.payload.text_byte;
    assign in_eot  = text_in.payload.end_of_text;
    assign accept  = text_in.valid && text_in.ready;
    assign out_ok  = !out_valid_reg || text_out.ready;

    assign is_nl  = (in_byte == CHAR_NL);
    assign is_sep = is_separator(in_byte);
    assign is_chr = !is_nl && !is_sep;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CFG_W'(1);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            w_eff = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
    end

    // Plan the whole output run of the byte: prefix, word drain, suffix.
    always_comb
    begin
        has_room  = (word_len_reg < LEN_W'(MAX_WIDTH));
        w1        = has_room ? (word_len_reg + LEN_W'(1)) : word_len_reg;
        full      = is_chr && (SUM_W'(w1) >= SUM_W'(w_eff));
        fin_len   = is_chr ? w1 : word_len_reg;
        do_finish = is_nl || is_sep || (is_chr && in_eot);
        ending    = is_nl || in_eot;

        plan_pfx      = PFX_NONE;
        plan_cnt      = '0;
        plan_word_len = '0;
        line_mid      = line_len_reg;

        if (full)
        begin
            plan_cnt = w1;
            line_mid = w1;
            if (line_len_reg != '0)
            begin
                plan_pfx = PFX_NEWLINE;
            end
        end
        else if (do_finish)
        begin
            plan_cnt = fin_len;
            if (fin_len != '0)
            begin
                if (line_len_reg == '0)
                begin
                    line_mid = fin_len;
                end
                else if ((SUM_W'(line_len_reg) + SUM_W'(1) + SUM_W'(fin_len))
                         <= SUM_W'(w_eff))
                begin
                    plan_pfx = PFX_SPACE;
                    line_mid = line_len_reg + LEN_W'(1) + fin_len;
                end
                else
                begin
                    plan_pfx = PFX_NEWLINE;
                    line_mid = fin_len;
                end
            end
        end
        else
        begin
            plan_word_len = w1;
        end

        plan_suffix = ending && (line_mid != '0);
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next    = state_reg;
        pfx_next      = pfx_reg;
        suffix_next   = suffix_reg;
        cnt_next      = cnt_reg;
        word_len_next = word_len_reg;
        line_len_next = line_len_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pfx_next      = plan_pfx;
                    suffix_next   = plan_suffix;
                    cnt_next      = plan_cnt;
                    word_len_next = plan_word_len;
                    line_len_next = ending ? '0 : line_mid;
                    if (plan_pfx != PFX_NONE)
                    begin
                        state_next = ST_PREFIX;
                    end
                    else if (plan_cnt != '0)
                    begin
                        state_next = ST_WORD;
                    end
                    else if (plan_suffix)
                    begin
                        state_next = ST_SUFFIX;
                    end
                end
            end
            ST_PREFIX:
            begin
                if (out_ok)
                begin
                    if (cnt_reg != '0)
                    begin
                        state_next = ST_WORD;
                    end
                    else if (suffix_reg)
                    begin
                        state_next = ST_SUFFIX;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WORD:
            begin
                if (out_ok)
                begin
                    cnt_next = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = suffix_reg ? ST_SUFFIX : ST_IDLE;
                    end
                end
            end
            ST_SUFFIX:
            begin
                if (out_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        emit        = 1'b0;
        emit_byte   = CHAR_NL;
        emit_last   = 1'b0;
        chain_shift = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                emit = 1'b0;
            end
            ST_PREFIX:
            begin
                emit      = out_ok;
                emit_byte = (pfx_reg == PFX_SPACE) ? CHAR_SP : CHAR_NL;
                emit_last = (cnt_reg == '0) && !suffix_reg;
            end
            ST_WORD:
            begin
                emit        = out_ok;
                chain_shift = out_ok;
                emit_byte   = chain_head;
                emit_last   = (cnt_reg == LEN_W'(1)) && !suffix_reg;
            end
            ST_SUFFIX:
            begin
                emit      = out_ok;
                emit_byte = CHAR_NL;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign text_in.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pfx_reg       <= PFX_NONE;
            suffix_reg    <= 1'b0;
            cnt_reg       <= '0;
            word_len_reg  <= '0;
            line_len_reg  <= '0;
            width_reg     <= LINE_WIDTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pfx_reg      <= pfx_next;
            suffix_reg   <= suffix_next;
            cnt_reg      <= cnt_next;
            word_len_reg <= word_len_next;
            line_len_reg <= line_len_next;
            if (cfg_wr_en)
            begin
                width_reg <= cfg_wr_data;
            end
            if (out_ok)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            run_last_reg <= emit_last;
        end
    end

    assign text_out.valid            = out_valid_reg;
    assign text_out.payload.out_byte = out_byte_reg;
    assign text_out.payload.run_last = run_last_reg;

    // A word character is stored at the first free cell when the item is taken and the chain has room.
    gww_chain #(
        .DEPTH (MAX_WIDTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk     (clk),
        .wr_en   (accept && is_chr && has_room),
        .wr_idx  (word_len_reg[IDX_W-1:0]),
        .wr_data (in_byte),
        .shift   (chain_shift),
        .head    (chain_head)
    );
endmodule
